>>> rtl/core/gf16rc_pkg.sv
`default_nettype none

package gf16rc_pkg;

  localparam int INPUT_BLOCKS = 32768;

  localparam int IDX_W = 15;
  localparam int REC_W = 16;
  localparam int GF_W  = 16;

  localparam logic [GF_W:0]   GF_POLY  = 17'h1100B;
  localparam logic [GF_W-1:0] GF_ORDER = 16'hFFFF;

  localparam int LOG_AW = (INPUT_BLOCKS > 1) ? $clog2(INPUT_BLOCKS) : 1;
  localparam int LOG_CW = LOG_AW + 1;

  localparam int EXP_ROM_SIZE = 8192;
  localparam int EXP_AW       = 13;
  localparam int EXP_SH_W     = 3;
  localparam int FIX_ROM_SIZE = 128;
  localparam int FIX_AW       = 7;

  // residue counters for the excluded-exponent test
  localparam logic [1:0] MOD3_LAST   = 2'd2;
  localparam logic [2:0] MOD5_LAST   = 3'd4;
  localparam logic [4:0] MOD17_LAST  = 5'd16;
  localparam logic [8:0] MOD257_LAST = 9'd256;

  typedef enum logic [1:0] {
    FILL_ST = 2'b01,
    RUN_ST  = 2'b10
  } fill_state_e;

  typedef struct packed {
    logic                  exp_we;
    logic [EXP_AW-1:0]     exp_waddr;
    logic [GF_W-1:0]       exp_wdata;
    logic                  log_we;
    logic [LOG_AW-1:0]     log_waddr;
    logic [GF_W-1:0]       log_wdata;
    logic                  done;
  } fill_wr_t;

  typedef logic [GF_W-1:0] fix_rom_t [FIX_ROM_SIZE];

  // reduction of the bits that spill above bit 15 after a shift of up to 7
  function automatic fix_rom_t build_fix_rom();
    fix_rom_t      rom;
    logic [GF_W:0] n;
    for (int i = 0; i < FIX_ROM_SIZE; i++) begin
      n = 17'(i) << 9;
      for (int j = 0; j < 7; j++) begin
        n = n << 1;
        if (n[GF_W]) begin
          n = n ^ GF_POLY;
        end
      end
      rom[i] = n[GF_W-1:0];
    end
    return rom;
  endfunction

  localparam fix_rom_t FIX_ROM = build_fix_rom();

endpackage

`default_nettype wire

>>> rtl/core/gf16rc_in_if.sv
`default_nettype none

interface gf16rc_in_if
  import gf16rc_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] input_block;
  logic [REC_W-1:0] recovery_block;

  modport source (output valid, output input_block, output recovery_block, input ready);
  modport sink   (input valid, input input_block, input recovery_block, output ready);
endinterface

`default_nettype wire

>>> rtl/core/gf16rc_out_if.sv
`default_nettype none

interface gf16rc_out_if
  import gf16rc_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [GF_W-1:0] coefficient;
  logic [GF_W-1:0] coefficient_log;

  modport source (output valid, output coefficient, output coefficient_log, input ready);
  modport sink   (input valid, input coefficient, input coefficient_log, output ready);
endinterface

`default_nettype wire

>>> rtl/core/gf16_recovery_coefficient_unit.sv
// Channel  Dir  Payload                           Handshake
// in_i     in   input_block, recovery_block      valid/ready
// out_o    out  coefficient, coefficient_log     valid/ready
//
// One word per cycle sustained while out_o.ready stays high; each result passes through the log
// memory read at the edge its input word is taken, then 16x16 multiply, fold plus exp memory read,
// shift and fix-up. After reset the log and exp memories are built by a sweep over every
// exponent; in_i.ready stays low until the sweep ends.
// Each stage advances when the one after it is empty or advancing, so bubbles close up
// and a new word is taken while a finished result waits in the output register.
`default_nettype none

module gf16_recovery_coefficient_unit
  import gf16rc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  gf16rc_in_if.sink     in_i,
  gf16rc_out_if.source  out_o
);

  fill_wr_t             fill_wr;
  logic                 va_q, vb_q, vc_q, vo_q;
  logic                 load_a, load_b, load_c, load_o;
  logic                 accept;
  logic [LOG_AW-1:0]    log_raddr;
  logic [IDX_W:0]       idx_ext;
  logic [GF_W-1:0]      log_rdata;
  logic [REC_W-1:0]     rec_a_q;
  logic [2*GF_W-1:0]    prod_q;
  logic [GF_W:0]        fold_sum;
  logic [GF_W-1:0]      fold_lg;
  logic [GF_W-1:0]      lg_c_q;
  logic [GF_W-1:0]      exp_rdata;
  logic [GF_W+FIX_AW-1:0] shifted;
  logic [GF_W-1:0]      coef_d;
  logic [GF_W-1:0]      coef_q, coef_log_q;

  gf16rc_fill u_fill (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_o   (fill_wr)
  );

  assign load_o = !vo_q || out_o.ready;
  assign load_c = !vc_q || load_o;
  assign load_b = !vb_q || load_c;
  assign load_a = !va_q || load_b;

  assign in_i.ready = fill_wr.done && load_a;
  assign accept     = in_i.valid && in_i.ready;

  // saturate indices past the last input block
  assign idx_ext = {1'b0, in_i.input_block};
  always_comb begin
    if (32'(idx_ext) >= INPUT_BLOCKS) begin
      log_raddr = LOG_AW'(INPUT_BLOCKS - 1);
    end else begin
      log_raddr = idx_ext[LOG_AW-1:0];
    end
  end

  gf16rc_ram #(.Width(GF_W), .Depth(INPUT_BLOCKS)) u_log_ram (
    .clk_i   (clk_i),
    .we_i    (fill_wr.log_we),
    .waddr_i (fill_wr.log_waddr),
    .wdata_i (fill_wr.log_wdata),
    .re_i    (in_i.ready),
    .raddr_i (log_raddr),
    .rdata_o (log_rdata)
  );

  // fold the product mod 65535 with an end-around carry
  assign fold_sum = {1'b0, prod_q[2*GF_W-1:GF_W]} + {1'b0, prod_q[GF_W-1:0]};
  assign fold_lg  = fold_sum[GF_W-1:0] + {{(GF_W-1){1'b0}}, fold_sum[GF_W]};

  gf16rc_ram #(.Width(GF_W), .Depth(EXP_ROM_SIZE)) u_exp_ram (
    .clk_i   (clk_i),
    .we_i    (fill_wr.exp_we),
    .waddr_i (fill_wr.exp_waddr),
    .wdata_i (fill_wr.exp_wdata),
    .re_i    (load_c),
    .raddr_i (fold_lg[GF_W-1:EXP_SH_W]),
    .rdata_o (exp_rdata)
  );

  always_comb begin
    shifted = {{FIX_AW{1'b0}}, exp_rdata} << lg_c_q[EXP_SH_W-1:0];
    coef_d  = shifted[GF_W-1:0] ^ FIX_ROM[shifted[GF_W+FIX_AW-1:GF_W]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (load_a) va_q <= accept;
      if (load_b) vb_q <= va_q;
      if (load_c) vc_q <= vb_q;
      if (load_o) vo_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready) begin
      rec_a_q <= in_i.recovery_block;
    end
    if (load_b) begin
      prod_q <= log_rdata * rec_a_q;
    end
    if (load_c) begin
      lg_c_q <= fold_lg;
    end
    if (load_o) begin
      coef_q     <= coef_d;
      coef_log_q <= lg_c_q;
    end
  end

  assign out_o.valid           = vo_q;
  assign out_o.coefficient     = coef_q;
  assign out_o.coefficient_log = coef_log_q;

endmodule

`default_nettype wire

>>> rtl/core/gf16rc_ram.sv
`default_nettype none

module gf16rc_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold the last word while the reader stalls
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/gf16rc_fill.sv
`default_nettype none

module gf16rc_fill
  import gf16rc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  output fill_wr_t  wr_o
);

  fill_state_e      state_q, state_d;
  logic [GF_W-1:0]  e_q, e_d;
  logic [GF_W-1:0]  n_q, n_d;
  logic [1:0]       m3_q, m3_d;
  logic [2:0]       m5_q, m5_d;
  logic [4:0]       m17_q, m17_d;
  logic [8:0]       m257_q, m257_d;
  logic [LOG_CW-1:0] i_q, i_d;
  logic [GF_W:0]    n_sh;
  logic             filling;
  logic             keep_next;
  logic             log_room;

  assign filling = (state_q == FILL_ST);

  always_comb begin
    m3_d   = (m3_q   == MOD3_LAST)   ? '0 : m3_q   + 2'd1;
    m5_d   = (m5_q   == MOD5_LAST)   ? '0 : m5_q   + 3'd1;
    m17_d  = (m17_q  == MOD17_LAST)  ? '0 : m17_q  + 5'd1;
    m257_d = (m257_q == MOD257_LAST) ? '0 : m257_q + 9'd1;
    n_sh   = {n_q, 1'b0};
    if (n_sh[GF_W]) begin
      n_sh = n_sh ^ GF_POLY;
    end
    n_d = n_sh[GF_W-1:0];
    e_d = e_q + 16'd1;
  end

  // next exponent is a usable log base when coprime to 65535
  assign keep_next = (m3_d != '0) && (m5_d != '0) && (m17_d != '0) && (m257_d != '0);
  assign log_room  = (i_q < LOG_CW'(INPUT_BLOCKS));

  always_comb begin
    i_d     = i_q;
    state_d = state_q;
    if (filling && keep_next && log_room) begin
      i_d = i_q + LOG_CW'(1);
    end
    if (filling && (e_q == GF_ORDER - 16'd1)) begin
      state_d = RUN_ST;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FILL_ST;
      e_q     <= '0;
      n_q     <= 16'd1;
      m3_q    <= '0;
      m5_q    <= '0;
      m17_q   <= '0;
      m257_q  <= '0;
      i_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      if (filling) begin
        e_q    <= e_d;
        n_q    <= n_d;
        m3_q   <= m3_d;
        m5_q   <= m5_d;
        m17_q  <= m17_d;
        m257_q <= m257_d;
      end
    end
  end

  always_comb begin
    wr_o.exp_we    = filling && (e_q[EXP_SH_W-1:0] == '0);
    wr_o.exp_waddr = e_q[GF_W-1:EXP_SH_W];
    wr_o.exp_wdata = n_q;
    wr_o.log_we    = filling && keep_next && log_room;
    wr_o.log_waddr = i_q[LOG_AW-1:0];
    wr_o.log_wdata = e_d;
    wr_o.done      = (state_q == RUN_ST);
  end

endmodule

`default_nettype wire
